FILE: hdl/three_wire_rtc_serial_master_unit_macros.svh
// ----------------------------------------------------------------------------
// three-wire rtc serial master assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_UNIT_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_UNIT_MACROS_SVH

// same-cycle implication
`define RTC3W_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTC3W_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// types, codes and helpers shared by the three-wire rtc serial master
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    localparam int MAX_BURST_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PUSH  = 2'd2;

    localparam logic [1:0] REG_HALF_BIT     = 2'd0;
    localparam logic [1:0] REG_BYTE_GAP     = 2'd1;
    localparam logic [1:0] REG_ENABLE_SETUP = 2'd2;

    localparam logic [7:0] HALF_BIT_RESET     = 8'd5;
    localparam logic [7:0] BYTE_GAP_RESET     = 8'd2;
    localparam logic [7:0] ENABLE_SETUP_RESET = 8'd4;

    localparam logic [7:0] CMD_WRITE_SET = 8'h80;
    localparam logic [7:0] CMD_READ_SET  = 8'h81;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_WLOW,
        PH_WHIGH,
        PH_GAP,
        PH_RLOW,
        PH_RHIGH,
        PH_CLOSE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_START,
        KIND_PUSH,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        sio_in;
        logic [7:0]  command;
        logic        read_not_write;
        logic [4:0]  length;
        logic [7:0]  write_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] half_bit_ticks;
        logic [7:0] byte_gap_ticks;
        logic [7:0] enable_setup_ticks;
    } cfg_t;

    typedef struct packed {
        logic       serial_clock;
        logic       chip_enable;
        logic       sio_out;
        logic       sio_drive;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
    } result_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [7:0] minus_one(input logic [7:0] v);
        return (v > 8'd1) ? (v - 8'd1) : 8'd1;
    endfunction

endpackage

FILE: hdl/rtc3w_front.sv
// ----------------------------------------------------------------------------
// rtc3w_front
// accepts stream words, decodes them into items and queues them for the back
// ----------------------------------------------------------------------------
module rtc3w_front #(
    parameter int MAX_BURST = rtc3w_pkg::MAX_BURST_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // sio_in, command_address[7:0], read_not_write, byte_count[4:0],
    // write_byte[7:0], zero pad
    input  logic [23:0]     s_tdata,
    // op[1:0]
    input  logic [1:0]      s_tuser,
    output logic            q_valid,
    output rtc3w_pkg::item_t q_item,
    input  logic            q_pop
);
    import rtc3w_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           item_in;
    logic [4:0]      count_in;
    logic            rnw_in;
    logic            push;

    item_t           q_mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    // decode the word into an item
    always_comb
    begin
        rnw_in   = s_tdata[9];
        count_in = s_tdata[14:10];
        case (s_tuser)
            OP_TICK:  item_in.kind = KIND_TICK;
            OP_START: item_in.kind = KIND_START;
            OP_PUSH:  item_in.kind = KIND_PUSH;
            default:  item_in.kind = KIND_NOP;
        endcase
        item_in.sio_in         = s_tdata[0];
        item_in.command        = s_tdata[8:1] | (rnw_in ? CMD_READ_SET : CMD_WRITE_SET);
        item_in.read_not_write = rnw_in;
        // writes are capped at the buffer depth
        if (!rnw_in && (int'(count_in) > MAX_BURST))
            item_in.length = 5'(MAX_BURST);
        else
            item_in.length = count_in;
        item_in.write_byte     = s_tdata[22:15];
    end

    assign s_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

FILE: hdl/rtc3w_back.sv
// ----------------------------------------------------------------------------
// rtc3w_back
// pin sequencer, write byte buffer and registered result stage
// ----------------------------------------------------------------------------
module rtc3w_back #(
    parameter int MAX_BURST = rtc3w_pkg::MAX_BURST_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rtc3w_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  rtc3w_pkg::item_t   q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rtc3w_pkg::result_t res
);
    import rtc3w_pkg::*;

    localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int FW = $clog2(MAX_BURST + 1);

    phase_t        phase_reg, phase_next;
    logic [7:0]    timer_reg, timer_next;
    logic [2:0]    bit_reg, bit_next;
    logic [5:0]    done_reg, done_next;
    logic [7:0]    shifter_reg, shifter_next;
    logic          is_read_reg, is_read_next;
    logic [4:0]    len_reg, len_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          in_cmd_reg, in_cmd_next;
    logic          sclk_reg, sclk_next;
    logic          ce_reg, ce_next;
    logic          sio_reg, sio_next;
    logic          drive_reg, drive_next;

    logic          out_valid_reg, out_valid_next;
    result_t       res_reg;
    result_t       res_next;

    logic [7:0]    buf_mem [MAX_BURST];
    logic [7:0]    buf_q;
    logic [6:0]    buf_addr;
    logic          buf_we;

    logic          go_wlow, go_rlow, go_gap, go_close;
    logic          next_wbyte, next_rbyte;
    logic          rd_valid, rd_last;
    logic [7:0]    rd_data;
    logic [5:0]    len6;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign res      = res_reg;
    assign len6     = {1'b0, len_reg};

    // prefetch the byte that the next byte boundary will load
    assign buf_addr = {1'b0, done_reg} + (in_cmd_reg ? 7'd0 : 7'd1);

    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_next     = bit_reg;
        done_next    = done_reg;
        shifter_next = shifter_reg;
        is_read_next = is_read_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        in_cmd_next  = in_cmd_reg;
        sclk_next    = sclk_reg;
        ce_next      = ce_reg;
        sio_next     = sio_reg;
        drive_next   = drive_reg;
        go_wlow      = 1'b0;
        go_rlow      = 1'b0;
        go_gap       = 1'b0;
        go_close     = 1'b0;
        next_wbyte   = 1'b0;
        next_rbyte   = 1'b0;
        buf_we       = 1'b0;
        rd_valid     = 1'b0;
        rd_last      = 1'b0;
        rd_data      = 8'd0;

        if (q_pop)
        begin
            case (q_item.kind)
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (timer_reg > 8'd1)
                            timer_next = timer_reg - 8'd1;
                        else
                        begin
                            case (phase_reg)
                                PH_SETUP: go_wlow = 1'b1;
                                PH_WLOW:
                                begin
                                    sclk_next  = 1'b1;
                                    timer_next = at_least_one(cfg.half_bit_ticks);
                                    phase_next = PH_WHIGH;
                                end
                                PH_WHIGH:
                                begin
                                    shifter_next = {1'b0, shifter_reg[7:1]};
                                    bit_next     = bit_reg + 3'd1;
                                    if (bit_reg != 3'd7)
                                        go_wlow = 1'b1;
                                    else if (in_cmd_reg)
                                    begin
                                        in_cmd_next = 1'b0;
                                        if (is_read_reg)
                                            next_rbyte = 1'b1;
                                        else
                                            next_wbyte = 1'b1;
                                    end
                                    else
                                    begin
                                        done_next  = done_reg + 6'd1;
                                        next_wbyte = 1'b1;
                                    end
                                end
                                PH_GAP:
                                begin
                                    if (is_read_reg)
                                        go_rlow = 1'b1;
                                    else
                                        go_wlow = 1'b1;
                                end
                                PH_RLOW:
                                begin
                                    shifter_next = {q_item.sio_in, shifter_reg[7:1]};
                                    sclk_next    = 1'b1;
                                    timer_next   = minus_one(cfg.half_bit_ticks);
                                    phase_next   = PH_RHIGH;
                                end
                                PH_RHIGH:
                                begin
                                    bit_next = bit_reg + 3'd1;
                                    if (bit_reg != 3'd7)
                                        go_rlow = 1'b1;
                                    else
                                    begin
                                        rd_valid   = 1'b1;
                                        rd_data    = shifter_reg;
                                        rd_last    = (done_reg == len6);
                                        done_next  = done_reg + 6'd1;
                                        next_rbyte = 1'b1;
                                    end
                                end
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                end
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        is_read_next = q_item.read_not_write;
                        len_next     = q_item.length;
                        shifter_next = q_item.command;
                        bit_next     = 3'd0;
                        done_next    = 6'd0;
                        in_cmd_next  = 1'b1;
                        sclk_next    = 1'b0;
                        ce_next      = 1'b1;
                        if (!q_item.read_not_write)
                        begin
                            fill_next = '0;
                            go_wlow   = 1'b1;
                        end
                        else if (cfg.enable_setup_ticks == 8'd0)
                            go_wlow = 1'b1;
                        else
                        begin
                            timer_next = cfg.enable_setup_ticks;
                            phase_next = PH_SETUP;
                        end
                    end
                end
                KIND_PUSH:
                begin
                    if ((phase_reg == PH_IDLE) && (fill_reg < FW'(MAX_BURST)))
                    begin
                        buf_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // byte boundary decisions
        if (next_wbyte)
        begin
            if (done_next < len6)
            begin
                shifter_next = buf_q;
                bit_next     = 3'd0;
                go_gap       = 1'b1;
            end
            else
                go_close = 1'b1;
        end
        if (next_rbyte)
        begin
            shifter_next = 8'd0;
            bit_next     = 3'd0;
            if (done_next < len6)
                go_gap = 1'b1;
            else if (done_next == len6)
                go_rlow = 1'b1;
            else
                go_close = 1'b1;
        end

        // a zero gap falls straight through to the next bit
        if (go_gap)
        begin
            if (cfg.byte_gap_ticks == 8'd0)
            begin
                if (is_read_reg)
                    go_rlow = 1'b1;
                else
                    go_wlow = 1'b1;
            end
            else
            begin
                timer_next = cfg.byte_gap_ticks;
                phase_next = PH_GAP;
            end
        end

        if (go_wlow)
        begin
            sclk_next  = 1'b0;
            drive_next = 1'b1;
            sio_next   = shifter_next[0];
            timer_next = minus_one(cfg.half_bit_ticks);
            phase_next = PH_WLOW;
        end
        if (go_rlow)
        begin
            sclk_next  = 1'b0;
            drive_next = 1'b0;
            timer_next = at_least_one(cfg.half_bit_ticks);
            phase_next = PH_RLOW;
        end
        if (go_close)
        begin
            ce_next    = 1'b0;
            timer_next = {1'b0, cfg.enable_setup_ticks[7:1]};
            phase_next = (cfg.enable_setup_ticks[7:1] == 7'd0) ? PH_IDLE : PH_CLOSE;
        end

        res_next.serial_clock = sclk_next;
        res_next.chip_enable  = ce_next;
        res_next.sio_out      = sio_next;
        res_next.sio_drive    = drive_next;
        res_next.read_data    = rd_data;
        res_next.read_valid   = rd_valid;
        res_next.read_last    = rd_last;
        res_next.busy_res     = (phase_next != PH_IDLE);

        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= 8'd0;
            bit_reg       <= 3'd0;
            done_reg      <= 6'd0;
            shifter_reg   <= 8'd0;
            is_read_reg   <= 1'b0;
            len_reg       <= 5'd0;
            fill_reg      <= '0;
            in_cmd_reg    <= 1'b0;
            sclk_reg      <= 1'b0;
            ce_reg        <= 1'b0;
            sio_reg       <= 1'b0;
            drive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_reg       <= bit_next;
            done_reg      <= done_next;
            shifter_reg   <= shifter_next;
            is_read_reg   <= is_read_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            in_cmd_reg    <= in_cmd_next;
            sclk_reg      <= sclk_next;
            ce_reg        <= ce_next;
            sio_reg       <= sio_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= res_next;
    end

    // write buffer, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[fill_reg[AW-1:0]] <= q_item.write_byte;
        if (buf_addr < 7'(MAX_BURST))
            buf_q <= buf_mem[buf_addr[AW-1:0]];
        else
            buf_q <= 8'd0;
    end

endmodule

FILE: hdl/three_wire_rtc_serial_master_unit.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit: tick driven three-wire rtc link master
// an accepted word is queued, then registered in the result stage as its result word
// throughput 1 word per cycle while the result sink is not stalling, one result word per input word
// reset: pins low, data pin released, config at defaults, buffer contents undefined
// ----------------------------------------------------------------------------
`include "three_wire_rtc_serial_master_unit_macros.svh"

module three_wire_rtc_serial_master_unit #(
    parameter int MAX_BURST = rtc3w_pkg::MAX_BURST_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sio_in, command_address[7:0], read_not_write, byte_count[4:0],
    // write_byte[7:0], zero pad
    input  logic [23:0]                    s_tdata,
    // op[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // serial_clock, chip_enable, sio_out, sio_drive, read_data[7:0], busy_res,
    // zero pad
    output logic [15:0]                    m_tdata,
    // read_valid
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtc3w_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rtc3w_pkg::*;

    cfg_t    cfg_reg;
    logic    cfg_we;
    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t res;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks     <= HALF_BIT_RESET;
            cfg_reg.byte_gap_ticks     <= BYTE_GAP_RESET;
            cfg_reg.enable_setup_ticks <= ENABLE_SETUP_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_HALF_BIT:     cfg_reg.half_bit_ticks     <= pwdata[7:0];
                REG_BYTE_GAP:     cfg_reg.byte_gap_ticks     <= pwdata[7:0];
                REG_ENABLE_SETUP: cfg_reg.enable_setup_ticks <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_HALF_BIT:     prdata = {24'd0, cfg_reg.half_bit_ticks};
            REG_BYTE_GAP:     prdata = {24'd0, cfg_reg.byte_gap_ticks};
            REG_ENABLE_SETUP: prdata = {24'd0, cfg_reg.enable_setup_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    rtc3w_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rtc3w_back #(
        .MAX_BURST (MAX_BURST)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tdata = {3'd0, res.busy_res, res.read_data, res.sio_drive, res.sio_out,
                      res.chip_enable, res.serial_clock};
    assign m_tuser = res.read_valid;
    assign m_tlast = res.read_last;

    // a full queue always has an item for the back
    `RTC3W_ASSERT_IMPLY(a_full_queue_nonempty, !s_tready, q_valid, "queue full but empty")
    // result drains when nothing is queued behind it
    `RTC3W_ASSERT_NEXT(a_result_drains, m_tvalid && m_tready && !q_valid, !m_tvalid, "stale result word")
    // a received byte never coincides with the master driving data
    `RTC3W_ASSERT_IMPLY(a_read_released, m_tvalid && m_tuser, !m_tdata[3], "read byte while driving")

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// three-wire rtc serial master testbench
// drives tick, start, push and nop words through the stream port and checks
// every result word against a cycle-free model of the pin sequencer or a
// directed expected word; the apb port is written and read back between runs,
// under several idling patterns
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc3w_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_TICKS = 190;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_DRAIN,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t  what;
        item_t      it;
        int         reps;
        bit         typed;
        result_t    want;
        logic [1:0] reg_sel;
        logic [7:0] reg_val;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state, tracked at the moment each word is accepted
    cfg_t       cfg = '{HALF_BIT_RESET, BYTE_GAP_RESET, ENABLE_SETUP_RESET};
    phase_t     seq_phase = PH_IDLE;
    logic [7:0] tick_timer = '0;
    logic [2:0] bit_pos = '0;
    logic [5:0] bytes_moved = '0;
    logic [7:0] shift_byte = '0;
    logic       xfer_read = 1'b0;
    logic [4:0] xfer_len = '0;
    logic [7:0] tx_buf [32];
    logic [5:0] tx_fill = '0;
    int         tx_known = 0;
    logic       pin_sclk = 1'b0;
    logic       pin_ce = 1'b0;
    logic       pin_sio = 1'b0;
    logic       pin_drive = 1'b0;
    logic       in_command = 1'b0;

    result_t    expected_reports [$];
    plan_row_t  directed_plan [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         sender_idle_pct = 0;
    int         sink_stall_pct = 0;

    three_wire_rtc_serial_master_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------- model of the pin sequencer ----------------

    function automatic void start_drive_low();
        pin_sclk = 1'b0;
        pin_drive = 1'b1;
        pin_sio = shift_byte[0];
        tick_timer = (cfg.half_bit_ticks > 8'd1) ? cfg.half_bit_ticks - 8'd1 : 8'd1;
        seq_phase = PH_WLOW;
    endfunction

    function automatic void start_sample_low();
        pin_sclk = 1'b0;
        pin_drive = 1'b0;
        tick_timer = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
        seq_phase = PH_RLOW;
    endfunction

    function automatic void release_enable();
        pin_ce = 1'b0;
        tick_timer = cfg.enable_setup_ticks >> 1;
        seq_phase = (tick_timer == 8'd0) ? PH_IDLE : PH_CLOSE;
    endfunction

    function automatic void start_byte_gap();
        if (cfg.byte_gap_ticks != 8'd0)
        begin
            tick_timer = cfg.byte_gap_ticks;
            seq_phase = PH_GAP;
        end
        else if (xfer_read)
            start_sample_low();
        else
            start_drive_low();
    endfunction

    function automatic void load_next_tx();
        if (bytes_moved < xfer_len)
        begin
            shift_byte = tx_buf[bytes_moved[4:0]];
            bit_pos = '0;
            start_byte_gap();
        end
        else
            release_enable();
    endfunction

    function automatic void load_next_rx();
        shift_byte = '0;
        bit_pos = '0;
        if (bytes_moved < xfer_len)
            start_byte_gap();
        else if (bytes_moved == xfer_len)
            start_sample_low();
        else
            release_enable();
    endfunction

    function automatic result_t next_pin_report(input item_t it);
        result_t r;
        r = '0;
        case (it.kind)
            KIND_TICK:
                if (seq_phase != PH_IDLE)
                begin
                    if (tick_timer > 8'd1)
                        tick_timer--;
                    else
                    begin
                        case (seq_phase)
                            PH_SETUP: start_drive_low();
                            PH_WLOW:
                            begin
                                pin_sclk = 1'b1;
                                tick_timer = (cfg.half_bit_ticks == 8'd0) ? 8'd1
                                                                          : cfg.half_bit_ticks;
                                seq_phase = PH_WHIGH;
                            end
                            PH_WHIGH:
                            begin
                                shift_byte = shift_byte >> 1;
                                bit_pos++;
                                if (bit_pos != 3'd0)
                                    start_drive_low();
                                else if (in_command && xfer_read)
                                begin
                                    in_command = 1'b0;
                                    load_next_rx();
                                end
                                else
                                begin
                                    if (in_command)
                                        in_command = 1'b0;
                                    else
                                        bytes_moved++;
                                    load_next_tx();
                                end
                            end
                            PH_GAP:
                                if (xfer_read)
                                    start_sample_low();
                                else
                                    start_drive_low();
                            PH_RLOW:
                            begin
                                shift_byte = {it.sio_in, shift_byte[7:1]};
                                pin_sclk = 1'b1;
                                tick_timer = (cfg.half_bit_ticks > 8'd1)
                                           ? cfg.half_bit_ticks - 8'd1 : 8'd1;
                                seq_phase = PH_RHIGH;
                            end
                            PH_RHIGH:
                            begin
                                bit_pos++;
                                if (bit_pos != 3'd0)
                                    start_sample_low();
                                else
                                begin
                                    r.read_valid = 1'b1;
                                    r.read_data = shift_byte;
                                    r.read_last = (bytes_moved == xfer_len);
                                    bytes_moved++;
                                    load_next_rx();
                                end
                            end
                            default: seq_phase = PH_IDLE;
                        endcase
                    end
                end
            KIND_START:
                if (seq_phase == PH_IDLE)
                begin
                    xfer_read = it.read_not_write;
                    xfer_len = it.length;
                    shift_byte = it.command | (xfer_read ? CMD_READ_SET : CMD_WRITE_SET);
                    bit_pos = '0;
                    bytes_moved = '0;
                    in_command = 1'b1;
                    pin_sclk = 1'b0;
                    pin_ce = 1'b1;
                    if (!xfer_read)
                    begin
                        tx_fill = '0;
                        start_drive_low();
                    end
                    else if (cfg.enable_setup_ticks == 8'd0)
                        start_drive_low();
                    else
                    begin
                        tick_timer = cfg.enable_setup_ticks;
                        seq_phase = PH_SETUP;
                    end
                end
            KIND_PUSH:
                if (seq_phase == PH_IDLE && tx_fill < 6'd32)
                begin
                    tx_buf[tx_fill[4:0]] = it.write_byte;
                    tx_fill++;
                    if (int'(tx_fill) > tx_known)
                        tx_known = int'(tx_fill);
                end
            default: ;
        endcase
        r.serial_clock = pin_sclk;
        r.chip_enable = pin_ce;
        r.sio_out = pin_sio;
        r.sio_drive = pin_drive;
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: result word expected none actual %h/%b/%b", $time,
                         m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("serial_clock", want.serial_clock, m_tdata[0]);
                check_field("chip_enable", want.chip_enable, m_tdata[1]);
                check_field("sio_out", want.sio_out, m_tdata[2]);
                check_field("sio_drive", want.sio_drive, m_tdata[3]);
                check_field("read_data", want.read_data, m_tdata[11:4]);
                check_field("busy_res", want.busy_res, m_tdata[12]);
                check_field("read_valid", want.read_valid, m_tuser);
                check_field("read_last", want.read_last, m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- stimulus ----------------

    function automatic item_t random_item(input kind_t k);
        item_t it;
        logic [31:0] noise;
        noise = $urandom;
        it = noise[24:0];
        it.kind = k;
        return it;
    endfunction

    task automatic send(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {1'b0, it.write_byte, it.length, it.read_not_write, it.command,
                    it.sio_in};
        do @(posedge clk); while (!s_tready);
        predicted = next_pin_report(it);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    // hold the stream until every result word is back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [1:0] sel, input logic [7:0] wval,
                             output logic [31:0] rval);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= {24'd0, wval};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rval = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input logic [1:0] sel, input logic [7:0] val);
        logic [31:0] back;
        settle();
        apb_cycle(1'b1, sel, val, back);
        case (sel)
            REG_HALF_BIT:     cfg.half_bit_ticks = val;
            REG_BYTE_GAP:     cfg.byte_gap_ticks = val;
            REG_ENABLE_SETUP: cfg.enable_setup_ticks = val;
            default: ;
        endcase
        apb_cycle(1'b0, sel, 8'd0, back);
        if (back !== {24'd0, val})
        begin
            $display("%0t: register %0d expected %0h actual %0h", $time, sel, val, back);
            mismatches++;
        end
    endtask

    function automatic void plan_item(input kind_t k, input logic sio, input logic [7:0] cmd,
                                      input logic rnw, input logic [4:0] len,
                                      input logic [7:0] wb, input int reps, input bit typed,
                                      input result_t want);
        plan_row_t row;
        row.what = ROW_ITEM;
        row.it = '{k, sio, cmd, rnw, len, wb};
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        row.reg_sel = '0;
        row.reg_val = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_drain();
        plan_row_t row;
        row.what = ROW_DRAIN;
        row.it = '0;
        row.reps = 0;
        row.typed = 1'b0;
        row.want = '0;
        row.reg_sel = '0;
        row.reg_val = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [1:0] sel, input logic [7:0] val);
        plan_row_t row;
        row.what = ROW_REG;
        row.it = '0;
        row.reps = 0;
        row.typed = 1'b0;
        row.want = '0;
        row.reg_sel = sel;
        row.reg_val = val;
        directed_plan.push_back(row);
    endfunction

    // optional pushes and start, then mostly ticks until the link is idle
    task automatic random_transfer(inout int ticks);
        item_t it;
        int    pushes;
        int    lim;
        pushes = ($urandom_range(15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 3);
        if ($urandom_range(49) == 0)
            settle();
        repeat (pushes) send(random_item(KIND_PUSH), 1'b0, '0);
        if ($urandom_range(7) == 0)
            send(random_item($urandom_range(1) ? KIND_TICK : KIND_NOP), 1'b0, '0);
        // now and then leave the pushes without a start
        if ($urandom_range(9) != 0)
        begin
            it = random_item(KIND_START);
            if (it.read_not_write)
                it.length = ($urandom_range(15) == 0) ? 5'($urandom_range(31))
                                                      : 5'($urandom_range(2));
            else
            begin
                // never let a write reach a buffer entry that was never filled
                lim = (tx_known > 31) ? 31 : tx_known;
                if ($urandom_range(7) != 0 && lim > 3)
                    lim = 3;
                it.length = 5'($urandom_range(lim));
            end
            send(it, 1'b0, '0);
        end
        while (seq_phase != PH_IDLE)
        begin
            if ($urandom_range(11) == 0)
                send(random_item(kind_t'($urandom_range(1, 3))), 1'b0, '0);
            else
            begin
                send(random_item(KIND_TICK), 1'b0, '0);
                ticks++;
            end
        end
    endtask

    initial
    begin : stimulus
        plan_row_t row;
        item_t     it;
        int        ticks;
        int        idle_set [4];
        int        stall_set [4];

        idle_set = '{0, 76, 0, 8};
        stall_set = '{0, 0, 76, 8};

        plan_item(KIND_TICK, 1'b0, 8'h00, 1'b0, 5'd0, 8'h00, 1, 1'b1, '0);
        plan_item(KIND_NOP, 1'b1, 8'hFF, 1'b1, 5'd31, 8'hFF, 1, 1'b1, '0);
        // one push more than the buffer holds
        plan_item(KIND_PUSH, 1'b0, 8'h00, 1'b0, 5'd0, 8'h00, 33, 1'b1, '0);
        plan_reg(REG_HALF_BIT, 8'd2);
        plan_reg(REG_BYTE_GAP, 8'd0);
        plan_reg(REG_ENABLE_SETUP, 8'd0);
        plan_item(KIND_START, 1'b0, 8'h00, 1'b0, 5'd31, 8'h00, 1, 1'b1,
                  '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1});
        // words arriving mid-transfer are dropped
        plan_item(KIND_PUSH, 1'b1, 8'hFF, 1'b1, 5'd31, 8'hFF, 1, 1'b0, '0);
        plan_item(KIND_START, 1'b1, 8'hFF, 1'b1, 5'd31, 8'hFF, 1, 1'b0, '0);
        plan_item(KIND_NOP, 1'b0, 8'h00, 1'b0, 5'd0, 8'h00, 1, 1'b0, '0);
        plan_drain();
        plan_item(KIND_START, 1'b0, 8'h00, 1'b1, 5'd0, 8'h00, 1, 1'b1,
                  '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1});
        plan_drain();
        plan_reg(REG_ENABLE_SETUP, 8'd1);
        plan_reg(REG_BYTE_GAP, 8'd255);
        plan_item(KIND_START, 1'b1, 8'h7E, 1'b1, 5'd1, 8'h00, 1, 1'b0, '0);
        plan_drain();
        plan_item(KIND_PUSH, 1'b0, 8'h00, 1'b0, 5'd0, 8'hFF, 1, 1'b0, '0);
        plan_item(KIND_START, 1'b0, 8'hFF, 1'b0, 5'd1, 8'h00, 1, 1'b0, '0);
        plan_drain();
        plan_reg(REG_HALF_BIT, 8'd255);
        plan_reg(REG_ENABLE_SETUP, 8'd255);
        plan_item(KIND_START, 1'b0, 8'h55, 1'b0, 5'd0, 8'h00, 1, 1'b0, '0);
        plan_drain();
        plan_item(KIND_START, 1'b0, 8'hAA, 1'b1, 5'd0, 8'h00, 1, 1'b0, '0);
        plan_drain();
        plan_reg(REG_HALF_BIT, 8'd5);
        plan_reg(REG_BYTE_GAP, 8'd2);
        plan_reg(REG_ENABLE_SETUP, 8'd4);
        plan_item(KIND_START, 1'b0, 8'h3C, 1'b1, 5'd2, 8'h00, 1, 1'b0, '0);
        plan_drain();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
        begin
            row = directed_plan[r];
            case (row.what)
                ROW_ITEM:
                    for (int k = 0; k < row.reps; k++)
                    begin
                        it = row.it;
                        it.write_byte = row.it.write_byte + 8'(k);
                        send(it, row.typed, row.want);
                    end
                ROW_DRAIN:
                    while (seq_phase != PH_IDLE) send(random_item(KIND_TICK), 1'b0, '0);
                default:
                    set_reg(row.reg_sel, row.reg_val);
            endcase
        end

        for (int p = 0; p < 4; p++)
        begin
            set_reg(REG_HALF_BIT, ($urandom_range(3) == 0) ? 8'($urandom_range(2, 12))
                                                           : 8'($urandom_range(2, 3)));
            set_reg(REG_BYTE_GAP, 8'($urandom_range(3)));
            set_reg(REG_ENABLE_SETUP, 8'($urandom_range(6)));
            sender_idle_pct = idle_set[p];
            sink_stall_pct = stall_set[p];
            ticks = 0;
            while (ticks < PHASE_TICKS) random_transfer(ticks);
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rtc3w_pkg.sv
hdl/rtc3w_front.sv
hdl/rtc3w_back.sv
hdl/three_wire_rtc_serial_master_unit.sv
sim/testbench.sv
